// ----- rtl/cfs_pkg.sv -----
// Shared types and constants for the Coulomb field summing block.
// Used by cfs_unit and coulomb_field_sum; no dependencies.
`timescale 1ns / 1ps
package cfs_pkg;

   // width of the shared arithmetic datapath
   localparam int unsigned UNIT_W = 128;
   // top bit of the square root search (operand stays below 2^65)
   localparam int unsigned SQRT_TOP = 64;
   localparam int unsigned CNT_W = $clog2(UNIT_W + 1);

   // configuration register indexes
   localparam logic REG_SCALE   = 1'b0;
   localparam logic REG_MIN_SEP = 1'b1;

   localparam logic [31:0] SCALE_RESET   = 32'd589160;
   localparam logic [30:0] MIN_SEP_RESET = 31'd3277;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_SQRT = 2'd2
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } cmd_type;

endpackage

// ----- rtl/coulomb_field_sum.sv -----
// Top level: sums the 2D Coulomb field of a stream of charges at a point.
// Depends on cfs_pkg and cfs_unit.
//
//   channel  dir  payload
//   req_     in   tdata: observer_x, observer_y, source_x, source_y, source_charge;
//                 tuser: skip_source; tlast: last_source
//   rsp_     out  tdata: field_x, field_y; tuser: saturated
//   csr_     in   index 0 coulomb_scale, index 1 min_separation
//
// From accept to accept, a charge runs seven multiplies, one root and two
// 128-step divides one after another on the shared unit in cfs_unit, each
// with a start, finish and hand-off.
// A skipped item goes from idle to ST_FIN and back. req_tready is high only while idle.
// A finished result waits in the output register; a later last item stalls
// until it is taken. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
module coulomb_field_sum #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,  // observer_x, observer_y, source_x, source_y, source_charge
   input  logic         req_tuser,  // skip_source
   input  logic         req_tlast,  // last_source
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // field_x, field_y
   output logic         rsp_tuser,  // saturated
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wdata
);
   localparam int unsigned W = cfs_pkg::UNIT_W;

   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_SQX  = 12'b000000000010,
      ST_SQY  = 12'b000000000100,
      ST_ROOT = 12'b000000001000,
      ST_D2   = 12'b000000010000,
      ST_D3   = 12'b000000100000,
      ST_COEF = 12'b000001000000,
      ST_NUMX = 12'b000010000000,
      ST_DIVX = 12'b000100000000,
      ST_NUMY = 12'b001000000000,
      ST_DIVY = 12'b010000000000,
      ST_FIN  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] scale_ff;
   logic [30:0] min_sep_ff;
   logic [31:0] ax_ff, ay_ff, qmag_ff;
   logic        xneg_ff, yneg_ff, qneg_ff, last_ff, pend_ff, pend_in;
   logic [33:0] dist_ff;
   logic [W-1:0] den_ff;
   logic [63:0] coef_ff;
   logic signed [47:0] sum_x_ff, sum_y_ff;
   logic        clip_ff;
   logic        rsp_valid_ff;
   logic [95:0] rsp_data_ff;
   logic        rsp_sat_ff;

   cfs_pkg::cmd_type cmd;
   logic [W-1:0] opa, opb, opc, res;
   logic         busy, done;

   logic signed [32:0] dx, dy;
   logic signed [31:0] qin;
   logic [30:0] floor_d;
   logic        term_neg, term_clip, sum_clip, out_free;
   logic signed [47:0] term, new_sum, cur_sum;
   logic signed [48:0] wide_sum;

   cfs_unit u_unit (
      .clock(clock), .reset(reset), .cmd(cmd), .opa(opa), .opb(opb), .opc(opc),
      .busy(busy), .done(done), .res(res)
   );

   // offsets of the incoming item
   always_comb begin
      dx  = 33'(signed'(req_tdata[31:0])) - 33'(signed'(req_tdata[95:64]));
      dy  = 33'(signed'(req_tdata[63:32])) - 33'(signed'(req_tdata[127:96]));
      qin = signed'(req_tdata[159:128]);
      floor_d = (min_sep_ff == '0) ? 31'd1 : min_sep_ff;
   end

   // pick unit operands by step
   always_comb begin
      opa = '0; opb = '0; opc = '0;
      cmd.op = cfs_pkg::OP_MUL;
      unique case (state_ff)
         ST_SQX:  begin opa = W'(ax_ff); opb = W'(ax_ff); end
         ST_SQY:  begin opa = W'(ay_ff); opb = W'(ay_ff); opc = res; end
         ST_ROOT: begin cmd.op = cfs_pkg::OP_SQRT; opa = res; end
         ST_D2:   begin opa = W'(dist_ff); opb = W'(dist_ff); end
         ST_D3:   begin opa = res; opb = W'(dist_ff); end
         ST_COEF: begin opa = W'(scale_ff); opb = W'(qmag_ff); end
         ST_NUMX: begin opa = W'(coef_ff); opb = W'(ax_ff); end
         ST_NUMY: begin opa = W'(coef_ff); opb = W'(ay_ff); end
         ST_DIVX, ST_DIVY: begin
            cmd.op = cfs_pkg::OP_DIV;
            opa = res << FRAC_BITS;
            opb = den_ff;
         end
         default: begin
            opa = '0;
         end
      endcase
      cmd.start = !pend_ff && (state_ff != ST_IDLE) && (state_ff != ST_FIN);
   end

   // clip the quotient to 48 bits and add it with saturation
   always_comb begin
      term_neg  = (state_ff == ST_DIVX) ? (xneg_ff != qneg_ff) : (yneg_ff != qneg_ff);
      term_clip = (res[W-1:48] != '0) ||
                  (term_neg ? (res[47] && res[46:0] != '0) : res[47]);
      if (term_clip) begin
         term = term_neg ? 48'sh800000000000 : 48'sh7FFFFFFFFFFF;
      end else begin
         term = term_neg ? -signed'(res[47:0]) : signed'(res[47:0]);
      end
      cur_sum  = (state_ff == ST_DIVX) ? sum_x_ff : sum_y_ff;
      wide_sum = 49'(cur_sum) + 49'(term);
      sum_clip = (wide_sum[48] != wide_sum[47]);
      if (sum_clip) begin
         new_sum = wide_sum[48] ? 48'sh800000000000 : 48'sh7FFFFFFFFFFF;
      end else begin
         new_sum = wide_sum[47:0];
      end
      out_free = !rsp_valid_ff || rsp_tready;
   end

   // step sequencer
   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      if (cmd.start) pend_in = 1'b1;
      if (done) pend_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = req_tuser ? ST_FIN : ST_SQX;
         ST_SQX:  if (done) state_in = ST_SQY;
         ST_SQY:  if (done) state_in = ST_ROOT;
         ST_ROOT: if (done) state_in = ST_D2;
         ST_D2:   if (done) state_in = ST_D3;
         ST_D3:   if (done) state_in = ST_COEF;
         ST_COEF: if (done) state_in = ST_NUMX;
         ST_NUMX: if (done) state_in = ST_DIVX;
         ST_DIVX: if (done) state_in = ST_NUMY;
         ST_NUMY: if (done) state_in = ST_DIVY;
         ST_DIVY: if (done) state_in = ST_FIN;
         ST_FIN:  if (!last_ff || out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      // capture the item
      if (req_tvalid && req_tready) begin
         ax_ff   <= dx[32] ? 32'(-dx) : dx[31:0];
         ay_ff   <= dy[32] ? 32'(-dy) : dy[31:0];
         xneg_ff <= dx[32];
         yneg_ff <= dy[32];
         qneg_ff <= qin[31];
         qmag_ff <= qin[31] ? 32'(-33'(qin)) : unsigned'(qin);
         last_ff <= req_tlast;
      end
      if (done && state_ff == ST_ROOT) begin
         dist_ff <= (res[33:0] < 34'(floor_d)) ? 34'(floor_d) : res[33:0];
      end
      if (done && state_ff == ST_D3) den_ff <= res;
      if (done && state_ff == ST_COEF) coef_ff <= res[63:0];
      if (state_ff == ST_FIN && last_ff && out_free) begin
         rsp_data_ff <= {sum_y_ff, sum_x_ff};
         rsp_sat_ff  <= clip_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         scale_ff     <= cfs_pkg::SCALE_RESET;
         min_sep_ff   <= cfs_pkg::MIN_SEP_RESET;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         // write configuration
         if (csr_we) begin
            unique case (csr_addr)
               cfs_pkg::REG_SCALE:   scale_ff   <= csr_wdata;
               cfs_pkg::REG_MIN_SEP: min_sep_ff <= csr_wdata[30:0];
               default: scale_ff <= scale_ff;
            endcase
         end
         // accumulate terms
         if (done && state_ff == ST_DIVX) begin
            sum_x_ff <= new_sum;
            clip_ff  <= clip_ff | term_clip | sum_clip;
         end
         if (done && state_ff == ST_DIVY) begin
            sum_y_ff <= new_sum;
            clip_ff  <= clip_ff | term_clip | sum_clip;
         end
         // hand off result and clear the sums
         if (state_ff == ST_FIN && last_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
            sum_x_ff     <= '0;
            sum_y_ff     <= '0;
            clip_ff      <= 1'b0;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!pend_ff && !busy)) else $error("unit busy when idle");
   a_done_owned: assert property (@(posedge clock) disable iff (reset)
      done |-> pend_ff) else $error("unit done without a request");
   a_dist_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_D2) |-> (dist_ff != '0)) else $error("zero distance");
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (sum_x_ff == '0 && sum_y_ff == '0 && !clip_ff))
      else $error("sums not cleared by reset");

endmodule

// ----- rtl/cfs_unit.sv -----
// Shared iterative arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root, all on one adder. Depends on cfs_pkg.
`timescale 1ns / 1ps
module cfs_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  cfs_pkg::cmd_type            cmd,
   input  logic [cfs_pkg::UNIT_W-1:0]  opa,
   input  logic [cfs_pkg::UNIT_W-1:0]  opb,
   input  logic [cfs_pkg::UNIT_W-1:0]  opc,
   output logic                        busy,
   output logic                        done,
   output logic [cfs_pkg::UNIT_W-1:0]  res
);
   localparam int unsigned W = cfs_pkg::UNIT_W;

   logic [W-1:0] ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in, rq_ff, rq_in;
   logic [cfs_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   cfs_pkg::op_type op_ff, op_in;
   logic busy_ff, busy_in, done_ff, done_in;

   logic [W-1:0] shl_rem, x_opd, y_opd;
   logic [W:0]   sum;
   logic         sub, finish;

   // one shared adder, subtract mode for divide and root
   always_comb begin
      shl_rem = {ra_ff[W-2:0], rc_ff[W-1]};
      sub     = (op_ff != cfs_pkg::OP_MUL);
      x_opd   = (op_ff == cfs_pkg::OP_DIV) ? shl_rem : ra_ff;
      y_opd   = (op_ff == cfs_pkg::OP_SQRT) ? (rb_ff | rc_ff) : rb_ff;
      sum     = {1'b0, x_opd} + {1'b0, sub ? ~y_opd : y_opd} + {{W{1'b0}}, sub};
      finish  = (op_ff == cfs_pkg::OP_DIV) ? (cnt_ff == '0) : (rc_ff == '0);
   end

   // sequence one step per cycle
   always_comb begin
      ra_in = ra_ff; rb_in = rb_ff; rc_in = rc_ff; rq_in = rq_ff;
      cnt_in = cnt_ff; op_in = op_ff; busy_in = busy_ff; done_in = 1'b0;
      if (cmd.start) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         cnt_in  = cfs_pkg::CNT_W'(W);
         rq_in   = '0;
         unique case (cmd.op)
            cfs_pkg::OP_MUL: begin
               ra_in = opc; rb_in = opa; rc_in = opb;
            end
            cfs_pkg::OP_DIV: begin
               ra_in = '0; rb_in = opb; rc_in = opa;
            end
            cfs_pkg::OP_SQRT: begin
               ra_in = opa; rb_in = '0; rc_in = W'(1) << cfs_pkg::SQRT_TOP;
            end
            default: begin
               ra_in = '0; rb_in = '0; rc_in = '0;
            end
         endcase
      end else if (busy_ff) begin
         if (finish) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            unique case (op_ff)
               cfs_pkg::OP_MUL: begin
                  if (rc_ff[0]) ra_in = sum[W-1:0];
                  rb_in = {rb_ff[W-2:0], 1'b0};
                  rc_in = {1'b0, rc_ff[W-1:1]};
               end
               cfs_pkg::OP_DIV: begin
                  ra_in  = sum[W] ? sum[W-1:0] : shl_rem;
                  rq_in  = {rq_ff[W-2:0], sum[W]};
                  rc_in  = {rc_ff[W-2:0], 1'b0};
                  cnt_in = cnt_ff - 1'b1;
               end
               cfs_pkg::OP_SQRT: begin
                  if (sum[W]) begin
                     ra_in = sum[W-1:0];
                     rb_in = {1'b0, rb_ff[W-1:1]} | rc_ff;
                  end else begin
                     rb_in = {1'b0, rb_ff[W-1:1]};
                  end
                  rc_in = {2'b00, rc_ff[W-1:2]};
               end
               default: begin
                  busy_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ra_ff <= ra_in; rb_ff <= rb_in; rc_ff <= rc_in; rq_ff <= rq_in;
      cnt_ff <= cnt_in; op_ff <= op_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign res  = (op_ff == cfs_pkg::OP_MUL) ? ra_ff :
                 (op_ff == cfs_pkg::OP_DIV) ? rq_ff : rb_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start) else $error("unit restarted while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while still busy");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && op_ff == cfs_pkg::OP_DIV && cnt_ff != '0) |=> busy_ff)
      else $error("divide ended early");

endmodule

// ----- bench/coulomb_field_sum_tb.sv -----
// Self-checking bench for coulomb_field_sum: directed rows, then random charge lists.
// Depends on cfs_pkg, cfs_unit and the coulomb_field_sum RTL; needs no other files.
`timescale 1ns / 1ps
module coulomb_field_sum_tb;

   localparam int unsigned FRAC = 16;
   localparam int unsigned SETTLE = 700;
   localparam longint FIELD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint FIELD_MIN = -64'sh0000_8000_0000_0000;

   typedef struct {
      logic [31:0] ox, oy, sx, sy, q;
      bit          skip, last;
   } charge_word_type;

   typedef struct {
      logic [47:0] fx, fy;
      bit          sat;
   } field_word_type;

   typedef struct {
      bit             fixed;
      field_word_type value;
   } known_field_type;

   typedef struct {
      charge_word_type w;
      known_field_type k;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;  // observer_x, observer_y, source_x, source_y, source_charge
   logic         req_tuser = 1'b0;  // skip_source
   logic         req_tlast = 1'b0;  // last_source
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;  // field_x, field_y
   logic         rsp_tuser;  // saturated
   logic         csr_we = 1'b0;
   logic         csr_addr = cfs_pkg::REG_SCALE;
   logic [31:0]  csr_wdata = '0;

   // predictor state
   logic [31:0]  model_scale = cfs_pkg::SCALE_RESET;
   logic [30:0]  model_min_sep = cfs_pkg::MIN_SEP_RESET;
   longint       acc_x = 0, acc_y = 0;
   bit           acc_clip = 0;

   field_word_type  field_q[$];
   known_field_type known_q[$];
   int           errors = 0, words_sent = 0, fields_checked = 0, clipped_seen = 0;
   int           hold_cycles = 0;
   bit           quiet = 0;

   coulomb_field_sum DUT (.*);

   always #10 clock = ~clock;

   // integer root, rounded down, of a sum of squares below 2^65
   function automatic logic [63:0] root_floor(logic [127:0] n);
      logic [63:0]  r, c;
      logic [127:0] c2;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (64'd1 << b);
         c2 = {64'd0, c} * {64'd0, c};
         if (c2 <= n) r = c;
      end
      return r;
   endfunction

   // one field component: delta * coef * 2^FRAC / den, truncated, clipped to 48 bits
   function automatic longint field_term(longint delta, logic [63:0] coef, bit coef_neg,
                                         logic [127:0] den);
      logic [127:0] mag, qt, lim;
      bit           neg;
      if (delta == 0 || coef == 0) return 0;
      mag = (delta < 0) ? 128'(-delta) : 128'(delta);
      neg = (delta < 0) != coef_neg;
      qt = ((mag * {64'd0, coef}) << FRAC) / den;
      lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
      if (qt > lim) begin
         acc_clip = 1;
         qt = lim;
      end
      return neg ? -longint'(qt[63:0]) : longint'(qt[63:0]);
   endfunction

   function automatic longint sum_clip(longint a, longint b);
      longint s;
      s = a + b;
      if (s > FIELD_MAX) begin
         acc_clip = 1;
         s = FIELD_MAX;
      end else if (s < FIELD_MIN) begin
         acc_clip = 1;
         s = FIELD_MIN;
      end
      return s;
   endfunction

   // advance the accumulated field by one word; returns 1 when a field is due
   function automatic bit accumulate_charge(charge_word_type w, output field_word_type f);
      longint       dx, dy, qv;
      logic [63:0]  coef, ax, ay, span, floor_d;
      logic [127:0] den;
      if (!w.skip) begin
         dx = longint'($signed(w.ox)) - longint'($signed(w.sx));
         dy = longint'($signed(w.oy)) - longint'($signed(w.sy));
         qv = longint'($signed(w.q));
         coef = {32'd0, model_scale} * 64'(qv < 0 ? -qv : qv);
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         span = root_floor({64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay});
         floor_d = (model_min_sep == 0) ? 64'd1 : 64'(model_min_sep);
         if (span < floor_d) span = floor_d;
         den = {64'd0, span} * {64'd0, span} * {64'd0, span};
         acc_x = sum_clip(acc_x, field_term(dx, coef, qv < 0, den));
         acc_y = sum_clip(acc_y, field_term(dy, coef, qv < 0, den));
      end
      f.fx = acc_x[47:0];
      f.fy = acc_y[47:0];
      f.sat = acc_clip;
      if (!w.last) return 0;
      acc_x = 0;
      acc_y = 0;
      acc_clip = 0;
      return 1;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      errors++;
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
   endtask

   // predict on accepted words, check accepted fields against the oldest expectation
   always @(posedge clock) begin
      charge_word_type w;
      field_word_type  f, want;
      known_field_type k;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            w.ox = req_tdata[31:0];
            w.oy = req_tdata[63:32];
            w.sx = req_tdata[95:64];
            w.sy = req_tdata[127:96];
            w.q = req_tdata[159:128];
            w.skip = req_tuser;
            w.last = req_tlast;
            k = known_q.pop_front();
            if (accumulate_charge(w, f)) field_q.push_back(k.fixed ? k.value : f);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (field_q.size() == 0) begin
               report_mismatch("unexpected field word", rsp_tdata[47:0], '0);
            end else begin
               want = field_q.pop_front();
               fields_checked++;
               if (rsp_tuser) clipped_seen++;
               if (rsp_tdata[47:0] !== want.fx)
                  report_mismatch("field_x", rsp_tdata[47:0], want.fx);
               if (rsp_tdata[95:48] !== want.fy)
                  report_mismatch("field_y", rsp_tdata[95:48], want.fy);
               if (rsp_tuser !== want.sat)
                  report_mismatch("saturated", 48'(rsp_tuser), 48'(want.sat));
            end
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // offer one word and hold it until taken; leaves valid high unless it pauses for a random gap
   task automatic send_word(charge_word_type w, known_field_type k);
      known_q.push_back(k);
      req_tvalid <= 1'b1;
      req_tdata <= {w.q, w.sy, w.sx, w.oy, w.ox};
      req_tuser <= w.skip;
      req_tlast <= w.last;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_plain(charge_word_type w);
      known_field_type none;
      none.fixed = 0;
      none.value = '{default: '0};
      send_word(w, none);
   endtask

   // pause the sender until all fields are out and the block has gone quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (field_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == cfs_pkg::REG_SCALE) model_scale = value;
      else model_min_sep = value[30:0];
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord(logic [31:0] base);
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return base + $urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000;
         default: return base + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      endcase
   endfunction

   // random lists: mostly well-formed lists around one observer, some stray words
   task automatic random_lists(int n_words);
      charge_word_type w;
      int              len, sent;
      sent = 0;
      while (sent < n_words) begin
         w.ox = ($urandom_range(0, 7) == 0) ? $urandom()
                : 32'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh1FF_FFFF);
         w.oy = ($urandom_range(0, 7) == 0) ? $urandom()
                : 32'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh1FF_FFFF);
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            w.sx = pick_coord(w.ox);
            w.sy = pick_coord(w.oy);
            case ($urandom_range(0, 3))
               0: w.q = $urandom();
               1: w.q = ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
               default: w.q = 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
            endcase
            w.skip = ($urandom_range(0, 9) == 0);
            w.last = (i == len - 1) || ($urandom_range(0, 19) == 0);
            send_plain(w);
            sent++;
         end
      end
   endtask

   initial begin
      stim_row_type    rows[$];
      stim_row_type    r;
      charge_word_type w;
      field_word_type  zero_field;
      zero_field = '{fx: '0, fy: '0, sat: 0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset settings; fixed expectations where obvious
      r.k.fixed = 1; r.k.value = zero_field;
      r.w = '{ox: 0, oy: 0, sx: 0, sy: 0, q: 0, skip: 1, last: 1};           // empty list
      rows.push_back(r);
      r.w = '{ox: 32'h0001_0000, oy: 5, sx: 7, sy: 3, q: 0, skip: 0, last: 1}; // zero charge
      rows.push_back(r);
      r.w = '{ox: 32'h8000_0000, oy: 32'h7FFF_FFFF, sx: 32'h8000_0000,
              sy: 32'h7FFF_FFFF, q: 32'h7FFF_FFFF, skip: 0, last: 1};       // coincident
      rows.push_back(r);
      r.w = '{ox: 1, oy: 1, sx: 9, sy: 9, q: 32'h0001_0000, skip: 1, last: 0}; // skip, no end
      rows.push_back(r);
      r.w = '{ox: 0, oy: 0, sx: 0, sy: 0, q: 0, skip: 1, last: 1};
      rows.push_back(r);
      r.k.fixed = 0;
      r.w = '{ox: 32'h0001_0000, oy: 0, sx: 0, sy: 0, q: 32'h0001_0000, skip: 0, last: 1};
      rows.push_back(r);
      r.w = '{ox: 1, oy: 0, sx: 0, sy: 0, q: 32'h7FFF_FFFF, skip: 0, last: 1};
      rows.push_back(r);
      r.w = '{ox: 32'h7FFF_FFFF, oy: 32'h8000_0000, sx: 32'h8000_0000,
              sy: 32'h7FFF_FFFF, q: 32'h8000_0000, skip: 0, last: 1};       // widest offsets
      rows.push_back(r);
      r.w = '{ox: 0, oy: 32'h0002_0000, sx: 32'h0001_0000, sy: 0,
              q: 32'hFFFF_0000, skip: 0, last: 0};
      rows.push_back(r);
      r.w = '{ox: 0, oy: 32'h0002_0000, sx: 32'hFFFF_0000, sy: 32'h0003_0000,
              q: 32'h0002_0000, skip: 0, last: 0};
      rows.push_back(r);
      r.w = '{ox: 0, oy: 32'h0002_0000, sx: 0, sy: 0, q: 32'h0000_8000, skip: 0, last: 1};
      rows.push_back(r);
      foreach (rows[i]) send_word(rows[i].w, rows[i].k);
      drain();

      // extremes: largest scale, tiniest floor; terms and sums clip
      write_reg(cfs_pkg::REG_SCALE, 32'hFFFF_FFFF);
      write_reg(cfs_pkg::REG_MIN_SEP, 32'd1);
      w = '{ox: 1, oy: 0, sx: 0, sy: 0, q: 32'h7FFF_FFFF, skip: 0, last: 1};
      send_plain(w);
      w = '{ox: 0, oy: 0, sx: 1, sy: 1, q: 32'h8000_0000, skip: 0, last: 0};
      send_plain(w);
      w.last = 1;
      send_plain(w);
      random_lists(400);
      drain();

      // zero scale and the widest floor
      write_reg(cfs_pkg::REG_SCALE, 32'd0);
      write_reg(cfs_pkg::REG_MIN_SEP, 32'h7FFF_FFFF);
      random_lists(60);
      drain();
      write_reg(cfs_pkg::REG_SCALE, 32'd589160);
      random_lists(300);
      drain();

      // floor of zero acts as one lsb; also fill up behind a long result stall
      write_reg(cfs_pkg::REG_MIN_SEP, 32'd0);
      hold_cycles = 3000;
      w = '{ox: 0, oy: 0, sx: 0, sy: 0, q: 0, skip: 1, last: 1};
      repeat (12) send_plain(w);
      random_lists(400);
      drain();

      // random settings, then a final stretch with no idling
      write_reg(cfs_pkg::REG_SCALE, $urandom());
      write_reg(cfs_pkg::REG_MIN_SEP, $urandom_range(1, 32'h0004_0000));
      random_lists(500);
      quiet = 1;
      random_lists(200);
      req_tvalid <= 1'b0;
      while (field_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Covered %0d charge words and %0d field results (%0d saturated)",
               words_sent, fields_checked, clipped_seen);
      $display("across reset, extreme, zero and random scale and separation settings.");
      if (errors == 0 && known_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #100_000_000;
      $display("Timeout with %0d fields outstanding", field_q.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/cfs_pkg.sv
rtl/cfs_unit.sv
rtl/coulomb_field_sum.sv
bench/coulomb_field_sum_tb.sv
